// ===== rtl/alc_pkg.sv =====
// ============================================================================
// alc_pkg: shared types and constants for the ambient light lux calculator
// Band edges, band coefficients, datapath widths and the divider stage word.
// ============================================================================
`default_nettype none

package alc_pkg;

    // Field and register widths
    localparam int CNT_W     = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int LUX_W     = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITIME = 2'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] GAIN_RST  = 8'd1;
    localparam logic [CFG_W-1:0] ITIME_RST = 8'd218;
    localparam logic [CFG_W-1:0] ITIME_MAX = 8'd255;

    // Ratio band test: 100*d1 against edge*d0
    localparam int RATIO_W = 24;
    localparam logic [RATIO_W-1:0] RATIO_PCT = 24'd100;
    localparam logic [RATIO_W-1:0] EDGE_LOW  = 24'd26;
    localparam logic [RATIO_W-1:0] EDGE_MID  = 24'd55;
    localparam logic [RATIO_W-1:0] EDGE_HIGH = 24'd109;
    localparam logic [RATIO_W-1:0] EDGE_TOP  = 24'd213;

    // Datapath widths
    localparam int COEF_W = 12;                 // coefficients in thousandths
    localparam int GS_W   = 2 * CFG_W;          // gain times step count
    localparam int PROD_W = CNT_W + COEF_W;     // coefficient times count
    localparam int DEN_W  = 31;                 // gain * 26992 * steps
    localparam int NUM_W  = 37;                 // (pos - neg) * 1026
    localparam int QUO_W  = LUX_W;              // quotient bits, one per stage
    localparam int CMP_W  = DEN_W + QUO_W;      // remainder compare width

    localparam logic [DEN_W-1:0] DEN_SCALE = 31'd26992;
    localparam logic [NUM_W-1:0] LUX_SCALE = 37'd1026;

    typedef enum logic [1:0] {
        BAND_LOW,
        BAND_MID,
        BAND_HIGH,
        BAND_TOP
    } alc_band_t;

    // Word carried through the divider stages
    typedef struct packed {
        logic             oob;
        logic             neg;
        logic             ovf;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } alc_div_t;

    // Visible channel coefficient of a band
    function automatic logic [COEF_W-1:0] band_c0(input alc_band_t band);
        logic [COEF_W-1:0] c;
        unique case (band)
            BAND_LOW:  c = 12'd1290;
            BAND_MID:  c = 12'd795;
            BAND_HIGH: c = 12'd510;
            BAND_TOP:  c = 12'd276;
            default:   c = 12'd0;
        endcase
        return c;
    endfunction

    // Infrared channel coefficient of a band
    function automatic logic [COEF_W-1:0] band_c1(input alc_band_t band);
        logic [COEF_W-1:0] c;
        unique case (band)
            BAND_LOW:  c = 12'd2733;
            BAND_MID:  c = 12'd859;
            BAND_HIGH: c = 12'd345;
            BAND_TOP:  c = 12'd130;
            default:   c = 12'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/alc_front.sv =====
// ============================================================================
// alc_front: five-stage front end of the lux calculator
// Band select, coefficient products, difference, scaling and overflow check;
// hands a dividend/divisor word to the divider pipeline.
// ============================================================================
`default_nettype none

module alc_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [alc_pkg::CFG_W-1:0]   gain,
    input  wire logic [alc_pkg::CFG_W-1:0]   integration_setting,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [alc_pkg::CNT_W-1:0]   visible_count,
    input  wire logic [alc_pkg::CNT_W-1:0]   infrared_count,
    output logic                             down_valid,
    output alc_pkg::alc_div_t                down_data,
    input  wire logic                        down_ready
);

    // Stage 1: counts, band, gain times steps
    logic                          s1_valid_reg;
    logic [alc_pkg::CNT_W-1:0]     s1_d0_reg;
    logic [alc_pkg::CNT_W-1:0]     s1_d1_reg;
    alc_pkg::alc_band_t            s1_band_reg;
    logic                          s1_oob_reg;
    logic [alc_pkg::GS_W-1:0]      s1_gs_reg;

    // Stage 2: coefficient products
    logic                          s2_valid_reg;
    logic [alc_pkg::PROD_W-1:0]    s2_pos_reg;
    logic [alc_pkg::PROD_W-1:0]    s2_neg_reg;
    logic                          s2_oob_reg;
    logic [alc_pkg::GS_W-1:0]      s2_gs_reg;

    // Stage 3: difference and divisor
    logic                          s3_valid_reg;
    logic [alc_pkg::PROD_W-1:0]    s3_diff_reg;
    logic                          s3_neg_reg;
    logic                          s3_oob_reg;
    logic [alc_pkg::DEN_W-1:0]     s3_den_reg;

    // Stage 4: scaled dividend
    logic                          s4_valid_reg;
    logic [alc_pkg::NUM_W-1:0]     s4_num_reg;
    logic                          s4_neg_reg;
    logic                          s4_oob_reg;
    logic [alc_pkg::DEN_W-1:0]     s4_den_reg;

    // Stage 5: overflow check, divider word
    logic                          s5_valid_reg;
    alc_pkg::alc_div_t             s5_reg;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic [alc_pkg::RATIO_W-1:0]   d0_ext;
    logic [alc_pkg::RATIO_W-1:0]   t100;
    alc_pkg::alc_band_t            band_next;
    logic                          oob_next;
    logic [alc_pkg::CFG_W-1:0]     g_eff;
    logic [alc_pkg::CFG_W-1:0]     steps;
    logic [alc_pkg::GS_W-1:0]      gs_next;
    logic [alc_pkg::PROD_W-1:0]    pos_next;
    logic [alc_pkg::PROD_W-1:0]    neg_next;
    logic [alc_pkg::PROD_W-1:0]    diff_next;
    logic                          negf_next;
    logic [alc_pkg::DEN_W-1:0]     den_next;
    logic [alc_pkg::NUM_W-1:0]     num_next;
    alc_pkg::alc_div_t             s5_next;

    // A stage takes a new beat when it is empty or its content moves on
    assign rdy5     = ~s5_valid_reg | down_ready;
    assign rdy4     = ~s4_valid_reg | rdy5;
    assign rdy3     = ~s3_valid_reg | rdy4;
    assign rdy2     = ~s2_valid_reg | rdy3;
    assign rdy1     = ~s1_valid_reg | rdy2;
    assign in_stall = ~rdy1;

    // Stage 1 logic: exact ratio band by cross-multiplication
    always_comb
    begin
        d0_ext = {{(alc_pkg::RATIO_W - alc_pkg::CNT_W){1'b0}}, visible_count};
        t100   = {{(alc_pkg::RATIO_W - alc_pkg::CNT_W){1'b0}}, infrared_count}
                 * alc_pkg::RATIO_PCT;
        oob_next = (visible_count == '0) || (t100 >= d0_ext * alc_pkg::EDGE_TOP);
        if (t100 < d0_ext * alc_pkg::EDGE_LOW)
        begin
            band_next = alc_pkg::BAND_LOW;
        end
        else if (t100 < d0_ext * alc_pkg::EDGE_MID)
        begin
            band_next = alc_pkg::BAND_MID;
        end
        else if (t100 < d0_ext * alc_pkg::EDGE_HIGH)
        begin
            band_next = alc_pkg::BAND_HIGH;
        end
        else
        begin
            band_next = alc_pkg::BAND_TOP;
        end

        // Treat gain zero as one and a zero step count as one
        g_eff = (gain == '0) ? {{(alc_pkg::CFG_W-1){1'b0}}, 1'b1} : gain;
        steps = alc_pkg::ITIME_MAX - integration_setting;
        if (steps == '0)
        begin
            steps = {{(alc_pkg::CFG_W-1){1'b0}}, 1'b1};
        end
        gs_next = {{alc_pkg::CFG_W{1'b0}}, g_eff} * {{alc_pkg::CFG_W{1'b0}}, steps};
    end

    // Stage 2 logic: coefficient products
    always_comb
    begin
        pos_next = {{alc_pkg::COEF_W{1'b0}}, s1_d0_reg}
                   * {{alc_pkg::CNT_W{1'b0}}, alc_pkg::band_c0(s1_band_reg)};
        neg_next = {{alc_pkg::COEF_W{1'b0}}, s1_d1_reg}
                   * {{alc_pkg::CNT_W{1'b0}}, alc_pkg::band_c1(s1_band_reg)};
    end

    // Stage 3 logic: difference, sign, divisor
    always_comb
    begin
        negf_next = s2_neg_reg > s2_pos_reg;
        diff_next = s2_pos_reg - s2_neg_reg;
        den_next  = {{(alc_pkg::DEN_W - alc_pkg::GS_W){1'b0}}, s2_gs_reg}
                    * alc_pkg::DEN_SCALE;
    end

    // Stage 4 logic: scale by 1026 (wraps only when the difference is negative)
    always_comb
    begin
        num_next = {{(alc_pkg::NUM_W - alc_pkg::PROD_W){1'b0}}, s3_diff_reg}
                   * alc_pkg::LUX_SCALE;
    end

    // Stage 5 logic: quotient above 16 bits when num >= den * 2^16
    always_comb
    begin
        s5_next.oob = s4_oob_reg;
        s5_next.neg = s4_neg_reg;
        s5_next.ovf = {{(alc_pkg::CMP_W - alc_pkg::NUM_W){1'b0}}, s4_num_reg}
                      >= {s4_den_reg, {alc_pkg::QUO_W{1'b0}}};
        s5_next.den = s4_den_reg;
        s5_next.rem = s4_num_reg;
        s5_next.quo = '0;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_d0_reg   <= visible_count;
            s1_d1_reg   <= infrared_count;
            s1_band_reg <= band_next;
            s1_oob_reg  <= oob_next;
            s1_gs_reg   <= gs_next;
        end
        if (rdy2)
        begin
            s2_pos_reg <= pos_next;
            s2_neg_reg <= neg_next;
            s2_oob_reg <= s1_oob_reg;
            s2_gs_reg  <= s1_gs_reg;
        end
        if (rdy3)
        begin
            s3_diff_reg <= diff_next;
            s3_neg_reg  <= negf_next;
            s3_oob_reg  <= s2_oob_reg;
            s3_den_reg  <= den_next;
        end
        if (rdy4)
        begin
            s4_num_reg <= num_next;
            s4_neg_reg <= s3_neg_reg;
            s4_oob_reg <= s3_oob_reg;
            s4_den_reg <= s3_den_reg;
        end
        if (rdy5)
        begin
            s5_reg <= s5_next;
        end
    end

    assign down_valid = s5_valid_reg;
    assign down_data  = s5_reg;

endmodule

`default_nettype wire

// ===== rtl/alc_div.sv =====
// ============================================================================
// alc_div: restoring divider pipeline and result register
// One quotient bit per stage, most significant first, then the clamp and
// flag logic into the output register.
// ============================================================================
`default_nettype none

module alc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        up_valid,
    input  wire alc_pkg::alc_div_t           up_data,
    output logic                             up_ready,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [alc_pkg::LUX_W-1:0]        lux,
    output logic                             out_of_band,
    output logic                             clamped
);

    logic                        stage_valid_reg [alc_pkg::QUO_W];
    alc_pkg::alc_div_t           stage_reg       [alc_pkg::QUO_W];
    alc_pkg::alc_div_t           stage_src       [alc_pkg::QUO_W];
    alc_pkg::alc_div_t           stage_next      [alc_pkg::QUO_W];
    logic                        src_valid       [alc_pkg::QUO_W];
    logic [alc_pkg::CMP_W-1:0]   dsh             [alc_pkg::QUO_W];
    logic [alc_pkg::CMP_W-1:0]   rem_ext         [alc_pkg::QUO_W];
    logic [alc_pkg::CMP_W-1:0]   rem_sub         [alc_pkg::QUO_W];
    logic [alc_pkg::QUO_W:0]     rdy;

    logic                        out_valid_reg;
    logic [alc_pkg::LUX_W-1:0]   lux_reg;
    logic                        oob_reg;
    logic                        clamped_reg;
    logic [alc_pkg::LUX_W-1:0]   lux_next;
    logic                        clamped_next;
    alc_pkg::alc_div_t           last;

    // Ready ripples back from the output register
    always_comb
    begin
        rdy[alc_pkg::QUO_W] = ~out_valid_reg | ~out_stall;
        for (int k = alc_pkg::QUO_W - 1; k >= 0; k--)
        begin
            rdy[k] = ~stage_valid_reg[k] | rdy[k+1];
        end
    end

    assign up_ready = rdy[0];

    // Feed each stage from the one before it
    always_comb
    begin
        stage_src[0] = up_data;
        src_valid[0] = up_valid;
        for (int k = 1; k < alc_pkg::QUO_W; k++)
        begin
            stage_src[k] = stage_reg[k-1];
            src_valid[k] = stage_valid_reg[k-1];
        end
    end

    // Trial subtract of the shifted divisor, one quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < alc_pkg::QUO_W; k++)
        begin
            dsh[k]     = {{alc_pkg::QUO_W{1'b0}}, stage_src[k].den}
                         << (alc_pkg::QUO_W - 1 - k);
            rem_ext[k] = {{(alc_pkg::CMP_W - alc_pkg::NUM_W){1'b0}}, stage_src[k].rem};
            rem_sub[k] = rem_ext[k] - dsh[k];
            stage_next[k] = stage_src[k];
            if (rem_ext[k] >= dsh[k])
            begin
                stage_next[k].rem = rem_sub[k][alc_pkg::NUM_W-1:0];
                stage_next[k].quo[alc_pkg::QUO_W - 1 - k] = 1'b1;
            end
        end
    end

    // Advance divider valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < alc_pkg::QUO_W; k++)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < alc_pkg::QUO_W; k++)
            begin
                if (rdy[k])
                begin
                    stage_valid_reg[k] <= src_valid[k];
                end
            end
        end
    end

    // Advance divider payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < alc_pkg::QUO_W; k++)
        begin
            if (rdy[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Apply band flag and clamping
    always_comb
    begin
        last = stage_reg[alc_pkg::QUO_W-1];
        if (last.oob || last.neg)
        begin
            lux_next = '0;
        end
        else if (last.ovf)
        begin
            lux_next = '1;
        end
        else
        begin
            lux_next = last.quo;
        end
        clamped_next = ~last.oob & (last.neg | last.ovf);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy[alc_pkg::QUO_W])
        begin
            out_valid_reg <= stage_valid_reg[alc_pkg::QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[alc_pkg::QUO_W])
        begin
            lux_reg     <= lux_next;
            oob_reg     <= last.oob;
            clamped_reg <= clamped_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lux         = lux_reg;
    assign out_of_band = oob_reg;
    assign clamped     = clamped_reg;

endmodule

`default_nettype wire

// ===== rtl/ambient_light_lux_calc_top.sv =====
// ============================================================================
// ambient_light_lux_calc_top: two-channel ambient light lux calculator
// Picks a linear formula by the infrared/visible ratio, scales by gain and
// integration time, divides, and clamps the result to 16 bits.
// ============================================================================
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  cfg       in         cfg_wr_en              cfg_index, cfg_data
//  in        in         in_valid / in_stall    visible_count, infrared_count
//  out       out        out_valid / out_stall  lux, out_of_band, clamped
//
//  One beat per cycle in and out while neither side is stalled. The path has
//  five front-end stages, sixteen divider stages (one quotient bit each) and
//  the output register. Each stage holds its own valid bit and fills whenever
//  it is empty, so bubbles close up while the output is stalled.
//  Reset clears the valid bits and loads gain 1, integration setting 218.
//  Configuration must be written only while no beat is in flight; the block does not enforce it.
//
`default_nettype none

module ambient_light_lux_calc_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [alc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [alc_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [alc_pkg::CNT_W-1:0]       visible_count,
    input  wire logic [alc_pkg::CNT_W-1:0]       infrared_count,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [alc_pkg::LUX_W-1:0]            lux,
    output logic                                 out_of_band,
    output logic                                 clamped
);

    logic [alc_pkg::CFG_W-1:0] gain_reg;
    logic [alc_pkg::CFG_W-1:0] itime_reg;
    logic [alc_pkg::CFG_W-1:0] gain_next;
    logic [alc_pkg::CFG_W-1:0] itime_next;

    logic                      mid_valid;
    alc_pkg::alc_div_t         mid_data;
    logic                      mid_ready;

    // Decode register writes; drop unknown indexes
    always_comb
    begin
        gain_next  = gain_reg;
        itime_next = itime_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                alc_pkg::REG_GAIN:  gain_next  = cfg_data;
                alc_pkg::REG_ITIME: itime_next = cfg_data;
                default:
                begin
                    gain_next  = gain_reg;
                    itime_next = itime_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= alc_pkg::GAIN_RST;
            itime_reg <= alc_pkg::ITIME_RST;
        end
        else
        begin
            gain_reg  <= gain_next;
            itime_reg <= itime_next;
        end
    end

    // Front end: band select through overflow check
    alc_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .gain                (gain_reg),
        .integration_setting (itime_reg),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .visible_count       (visible_count),
        .infrared_count      (infrared_count),
        .down_valid          (mid_valid),
        .down_data           (mid_data),
        .down_ready          (mid_ready)
    );

    // Divider and result register
    alc_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (mid_valid),
        .up_data     (mid_data),
        .up_ready    (mid_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lux         (lux),
        .out_of_band (out_of_band),
        .clamped     (clamped)
    );

    // An out-of-band result carries zero lux and no clamp flag
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_band |-> lux == '0 && !clamped)
        else $error("out-of-band result with nonzero lux or clamp flag");

    // A clamped result sits at one of the two rails
    a_clamp_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> lux == '0 || lux == '1)
        else $error("clamped result not at a rail");

    // With the output register empty every stage can take a beat
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire

// ===== verif/ambient_light_lux_calc_top_test.sv =====
// ============================================================================
// ambient_light_lux_calc_top_test: self-checking bench for the lux calculator
// Sends count pairs through the valid/stall input port under several gain
// and integration settings, predicts every result in the bench and compares
// each output beat field by field, with random idle and stall bursts.
// ============================================================================
`timescale 1ns / 1ps

module ambient_light_lux_calc_top_test;

    // Unused register slots; writes there must change nothing
    localparam logic [alc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [alc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [63:0] LUX_NUM   = 64'd1026;
    localparam logic [63:0] STEP_DEN  = 64'd26992;
    localparam logic [63:0] LUX_CEIL  = 64'd65535;
    localparam int          N_PHASES  = 8;
    localparam int          PHASE_PAIRS = 166;
    localparam int          TAIL_CYCLES = 30;

    typedef struct packed {
        logic [alc_pkg::LUX_W-1:0] lux;
        logic                      oob;
        logic                      clamped;
    } lux_result_t;

    typedef struct packed {
        logic [alc_pkg::CNT_W-1:0] vis;
        logic [alc_pkg::CNT_W-1:0] ir;
        logic                      known;
        lux_result_t               res;
    } stim_row_t;

    localparam int N_DIRECTED = 22;

    // Directed pairs at reset settings (gain 1, integration 218); known
    // results only where they follow directly, the rest go to the predictor
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{16'd0,     16'd0,     1'b1, '{16'd0,     1'b1, 1'b0}},
        '{16'd0,     16'd65535, 1'b1, '{16'd0,     1'b1, 1'b0}},
        '{16'd65535, 16'd0,     1'b1, '{16'd65535, 1'b0, 1'b1}},
        '{16'd1,     16'd0,     1'b0, '0},
        '{16'd65535, 16'd65535, 1'b0, '0},
        '{16'd100,   16'd213,   1'b1, '{16'd0,     1'b1, 1'b0}},
        '{16'd100,   16'd212,   1'b0, '0},
        '{16'd1000,  16'd2125,  1'b1, '{16'd0,     1'b0, 1'b1}},
        '{16'd100,   16'd25,    1'b0, '0},
        '{16'd100,   16'd26,    1'b0, '0},
        '{16'd100,   16'd54,    1'b0, '0},
        '{16'd100,   16'd55,    1'b0, '0},
        '{16'd100,   16'd108,   1'b0, '0},
        '{16'd100,   16'd109,   1'b0, '0},
        '{16'd65535, 16'd17039, 1'b0, '0},
        '{16'd65535, 16'd17040, 1'b0, '0},
        '{16'd1,     16'd2,     1'b0, '0},
        '{16'd1,     16'd3,     1'b1, '{16'd0,     1'b1, 1'b0}},
        '{16'd30000, 16'd65535, 1'b1, '{16'd0,     1'b1, 1'b0}},
        '{16'd43690, 16'd21845, 1'b0, '0},
        '{16'd21845, 16'd43690, 1'b0, '0},
        '{16'd32768, 16'd255,   1'b0, '0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [alc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [alc_pkg::CFG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [alc_pkg::CNT_W-1:0]     visible_count;
    logic [alc_pkg::CNT_W-1:0]     infrared_count;
    logic                          out_valid;
    logic                          out_stall;
    logic [alc_pkg::LUX_W-1:0]     lux;
    logic                          out_of_band;
    logic                          clamped;

    // Bench copy of the configuration registers
    logic [alc_pkg::CFG_W-1:0] cfg_gain  = alc_pkg::GAIN_RST;
    logic [alc_pkg::CFG_W-1:0] cfg_itime = alc_pkg::ITIME_RST;

    lux_result_t pending_lux [$];
    bit          idle_on;
    int          mismatches;
    int          pairs_sent;
    int          results_seen;
    int          oob_seen;
    int          clamp_seen;
    int          settings_used;

    ambient_light_lux_calc_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .visible_count  (visible_count),
        .infrared_count (infrared_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lux            (lux),
        .out_of_band    (out_of_band),
        .clamped        (clamped)
    );

    always #5 clk = ~clk;

    // Work out the result of one count pair under the current settings
    function automatic lux_result_t predict_lux(input logic [alc_pkg::CNT_W-1:0] d0,
                                                input logic [alc_pkg::CNT_W-1:0] d1);
        lux_result_t         r;
        alc_pkg::alc_band_t  band;
        logic [63:0] vis;
        logic [63:0] ir;
        logic [63:0] pct;
        logic [63:0] c0;
        logic [63:0] c1;
        logic [63:0] g;
        logic [63:0] steps;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] quo;
        r   = '0;
        vis = d0;
        ir  = d1;
        pct = ir * 100;
        if (vis == 0 || pct >= vis * 213)
        begin
            r.oob = 1'b1;
        end
        else
        begin
            if (pct < vis * 26)
                band = alc_pkg::BAND_LOW;
            else if (pct < vis * 55)
                band = alc_pkg::BAND_MID;
            else if (pct < vis * 109)
                band = alc_pkg::BAND_HIGH;
            else
                band = alc_pkg::BAND_TOP;
            case (band)
                alc_pkg::BAND_LOW:
                begin
                    c0 = 1290;
                    c1 = 2733;
                end
                alc_pkg::BAND_MID:
                begin
                    c0 = 795;
                    c1 = 859;
                end
                alc_pkg::BAND_HIGH:
                begin
                    c0 = 510;
                    c1 = 345;
                end
                default:
                begin
                    c0 = 276;
                    c1 = 130;
                end
            endcase
            // Zero gain acts as one; the top integration code acts as one step
            g     = (cfg_gain == 0) ? 64'd1 : 64'(cfg_gain);
            steps = (cfg_itime == alc_pkg::ITIME_MAX) ? 64'd1
                                                      : 64'(alc_pkg::ITIME_MAX - cfg_itime);
            pos   = c0 * vis;
            neg   = c1 * ir;
            if (neg > pos)
            begin
                r.clamped = 1'b1;
            end
            else
            begin
                quo = ((pos - neg) * LUX_NUM) / (g * STEP_DEN * steps);
                if (quo > LUX_CEIL)
                begin
                    r.clamped = 1'b1;
                    r.lux     = LUX_CEIL[alc_pkg::LUX_W-1:0];
                end
                else
                begin
                    r.lux = quo[alc_pkg::LUX_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // Present one beat, hold it until accepted, then log its expected result
    task automatic send_pair(input logic [alc_pkg::CNT_W-1:0] d0,
                             input logic [alc_pkg::CNT_W-1:0] d1,
                             input logic known, input lux_result_t known_res);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        visible_count  <= d0;
        infrared_count <= d1;
        do @(posedge clk); while (in_stall);
        pending_lux.push_back(known ? known_res : predict_lux(d0, d1));
        pairs_sent++;
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_lux.size() != 0) @(posedge clk);
    endtask

    // Write both spare slots and both registers back to back, then lower enable
    task automatic program_settings(input logic [alc_pkg::CFG_W-1:0] g,
                                    input logic [alc_pkg::CFG_W-1:0] it);
        logic [alc_pkg::CFG_IDX_W-1:0] idx [4];
        logic [alc_pkg::CFG_W-1:0]     val [4];
        idx = '{REG_SPARE_A, alc_pkg::REG_GAIN, REG_SPARE_B, alc_pkg::REG_ITIME};
        val = '{alc_pkg::CFG_W'($urandom), g, alc_pkg::CFG_W'($urandom), it};
        for (int k = 0; k < 4; k++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            if (idx[k] == alc_pkg::REG_GAIN)
                cfg_gain = val[k];
            else if (idx[k] == alc_pkg::REG_ITIME)
                cfg_itime = val[k];
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Draw a count pair: mostly steered into a ratio band, some raw noise
    task automatic pick_counts(output logic [alc_pkg::CNT_W-1:0] d0,
                               output logic [alc_pkg::CNT_W-1:0] d1);
        int v;
        int w;
        int k;
        v = $urandom_range(0, 65535) >> $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                v = $urandom_range(0, 65535);
                w = $urandom_range(0, 65535);
            end
            2, 3, 4, 5, 6:
            begin
                k = $urandom_range(0, 220);
                w = (v * k + $urandom_range(0, 99)) / 100;
            end
            7:
            begin
                v = ($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(0, 1);
                w = ($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(0, 65535);
            end
            8:
            begin
                // ratio just under the top edge, where the raw value goes negative
                v = $urandom_range(1000, 30000);
                w = (v * 2124 + $urandom_range(0, v * 6)) / 1000;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       k = 26;
                    1:       k = 55;
                    2:       k = 109;
                    default: k = 213;
                endcase
                v = $urandom_range(1, 655) * 100;
                w = v * k / 100 + $urandom_range(0, 2) - 1;
            end
        endcase
        if (w < 0)
            w = 0;
        if (w > 65535)
            w = 65535;
        d0 = alc_pkg::CNT_W'(v);
        d1 = alc_pkg::CNT_W'(w);
    endtask

    // Output side: check accepted beats, stall in random bursts
    initial
    begin
        int          stall_left;
        lux_result_t want;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_lux.size() == 0)
                begin
                    $error("unexpected result beat: lux %0d", lux);
                    mismatches++;
                end
                else
                begin
                    want = pending_lux.pop_front();
                    results_seen++;
                    if (out_of_band === 1'b1)
                        oob_seen++;
                    if (clamped === 1'b1)
                        clamp_seen++;
                    if (lux !== want.lux)
                    begin
                        $error("lux: expected %0d, got %0d", want.lux, lux);
                        mismatches++;
                    end
                    if (out_of_band !== want.oob)
                    begin
                        $error("out_of_band: expected %0d, got %0d", want.oob, out_of_band);
                        mismatches++;
                    end
                    if (clamped !== want.clamped)
                    begin
                        $error("clamped: expected %0d, got %0d", want.clamped, clamped);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 14);
                out_stall <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [alc_pkg::CNT_W-1:0] d0;
        logic [alc_pkg::CNT_W-1:0] d1;
        logic [alc_pkg::CFG_W-1:0] g;
        logic [alc_pkg::CFG_W-1:0] it;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= alc_pkg::REG_GAIN;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        visible_count  <= '0;
        infrared_count <= '0;
        idle_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs at reset settings
        settings_used = 1;
        for (int i = 0; i < N_DIRECTED; i++)
            send_pair(directed_rows[i].vis, directed_rows[i].ir,
                      directed_rows[i].known, directed_rows[i].res);
        drain_pipeline();

        // Random pairs under a series of settings, extremes first
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    g       = 8'd0;
                    it      = 8'd255;
                    idle_on = 1'b1;
                end
                1:
                begin
                    g       = 8'd128;
                    it      = 8'd0;
                    idle_on = 1'b1;
                end
                2:
                begin
                    g       = 8'd255;
                    it      = 8'd254;
                    idle_on = 1'b0;
                end
                3:
                begin
                    g       = 8'd1;
                    it      = 8'd255;
                    idle_on = 1'b1;
                end
                4:
                begin
                    g       = 8'd16;
                    it      = 8'd218;
                    idle_on = 1'b1;
                end
                default:
                begin
                    g  = alc_pkg::CFG_W'($urandom_range(1, 128));
                    it = alc_pkg::CFG_W'($urandom_range(0, 254));
                    idle_on = (p != N_PHASES - 1);
                end
            endcase
            program_settings(g, it);
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                pick_counts(d0, d1);
                send_pair(d0, d1, 1'b0, '0);
            end
            drain_pipeline();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_lux.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_lux.size());
            mismatches++;
        end
        $display("covered %0d count pairs over %0d register settings",
                 pairs_sent, settings_used);
        $display("checked %0d results: %0d out of band, %0d clamped",
                 results_seen, oob_seen, clamp_seen);
        if (mismatches == 0)
            $display("[ambient_light_lux_calc_top] OK");
        else
            $display("[ambient_light_lux_calc_top] ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5000000;
        $display("[ambient_light_lux_calc_top] ERROR");
        $finish;
    end

endmodule
